/* rtl/mpcr_pkg.sv */
// shared types, register indexes and the median edge detector function
// for the med predict column replace block; no dependencies
package mpcr_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_INTERVAL = 2'd1;

  // configuration field widths and reset values
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned LW_W       = 10;
  localparam int unsigned MI_W       = 8;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST    = 10'd512;
  localparam logic [MI_W-1:0] MARK_INTERVAL_RST = 8'd10;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // per item decisions taken by the front
  typedef struct packed {
    logic rep;
    logic first_row;
  } ctrl_t;

  // median edge detector for one channel
  function automatic logic [7:0] med_chan(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] res;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) begin
      res = lo;
    end else if (c <= lo) begin
      res = hi;
    end else begin
      res = a + b - c;
    end
    return res;
  endfunction

  function automatic pix_t med_pix(input pix_t a, input pix_t b, input pix_t c);
    pix_t r;
    r.red   = med_chan(a.red, b.red, c.red);
    r.green = med_chan(a.green, b.green, c.green);
    r.blue  = med_chan(a.blue, b.blue, c.blue);
    return r;
  endfunction

endpackage

/* rtl/med_predict_column_replace.sv */
// top level of the med predict column replace block: configuration
// registers, front end, queue and back end; uses mpcr_pkg and all mpcr_ modules
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  frame_start_i, red/green/blue_in_i
//   out      output     out_valid_o / out_stall_i red/green/blue_out_o, replaced_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one pixel per clock sustained while out_stall_i is low; an accepted pixel
// passes through the queue slot, the line store read and the output register.
// the line store read of one pixel overlaps the retire of the one ahead, a
// bypass covers a write to the same column.
// reset clears the position counters and sets the first row; the line store
// is not cleared, the first row of each frame writes it before it is read.
// an output stall holds the output register, then the back stage, then fills
// the two entry queue before in_stall_o rises.
module med_predict_column_replace #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               frame_start_i,
  input  logic [7:0]                         red_in_i,
  input  logic [7:0]                         green_in_i,
  input  logic [7:0]                         blue_in_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         red_out_o,
  output logic [7:0]                         green_out_o,
  output logic [7:0]                         blue_out_o,
  output logic                               replaced_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mpcr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mpcr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mpcr_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ITEM_W = COL_W + $bits(ctrl_t) + $bits(pix_t);

  logic [LW_W-1:0]   line_width_q;
  logic [MI_W-1:0]   mark_interval_q;

  pix_t              in_pix;
  pix_t              out_pix;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;
  logic [COL_W-1:0]  f_col;
  ctrl_t             f_ctrl;
  pix_t              f_pix;
  logic [ITEM_W-1:0] q_wdata;
  logic [ITEM_W-1:0] q_rdata;
  logic [COL_W-1:0]  b_col;
  ctrl_t             b_ctrl;
  pix_t              b_pix;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q    <= LINE_WIDTH_RST;
      mark_interval_q <= MARK_INTERVAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LINE_WIDTH:    line_width_q    <= cfg_data_i[LW_W-1:0];
        REG_MARK_INTERVAL: mark_interval_q <= cfg_data_i[MI_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_pix.red   = red_in_i;
  assign in_pix.green = green_in_i;
  assign in_pix.blue  = blue_in_i;

  mpcr_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .frame_start_i  (frame_start_i),
    .pix_i          (in_pix),
    .line_width_i   (line_width_q),
    .mark_interval_i(mark_interval_q),
    .q_full_i       (q_full),
    .push_o         (push),
    .col_o          (f_col),
    .ctrl_o         (f_ctrl),
    .pix_o          (f_pix)
  );

  // queue between front and back
  assign q_wdata = {f_col, f_ctrl, f_pix};

  mpcr_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_rdata),
    .pop_i  (pop)
  );

  assign {b_col, b_ctrl, b_pix} = q_rdata;

  mpcr_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_col_i    (b_col),
    .q_ctrl_i   (b_ctrl),
    .q_pix_i    (b_pix),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pix_o      (out_pix),
    .replaced_o (replaced_o)
  );

  assign red_out_o   = out_pix.red;
  assign green_out_o = out_pix.green;
  assign blue_out_o  = out_pix.blue;

endmodule

/* rtl/mpcr_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module mpcr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, returns old data on a same address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/mpcr_front.sv */
// front end: accepts pixels, tracks column, interval phase and first row,
// and tags each pixel for the back end; uses mpcr_pkg
module mpcr_front #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        frame_start_i,
  input  mpcr_pkg::pix_t              pix_i,
  input  logic [mpcr_pkg::LW_W-1:0]   line_width_i,
  input  logic [mpcr_pkg::MI_W-1:0]   mark_interval_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output logic [$clog2(MAX_WIDTH)-1:0] col_o,
  output mpcr_pkg::ctrl_t             ctrl_o,
  output mpcr_pkg::pix_t              pix_o
);
  import mpcr_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;

  logic [COL_W-1:0] col_q, col_d;
  logic [MI_W-1:0]  phase_q, phase_d;
  logic             first_q, first_d;

  logic [COL_W-1:0] cur_col;
  logic [MI_W-1:0]  cur_phase;
  logic [MI_W-1:0]  phase_inc;
  logic             cur_first;
  logic [CMP_W-1:0] lw_ext;
  logic [CMP_W-1:0] width_eff;
  logic [CMP_W-1:0] col_inc;
  logic             push;

  assign in_stall_o = q_full_i;
  assign push       = in_valid_i && !q_full_i;
  assign push_o     = push;

  // effective row width, zero acts as one, saturates at the store depth
  assign lw_ext = CMP_W'(line_width_i);
  always_comb begin
    if (lw_ext == '0) begin
      width_eff = CMP_W'(1);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = CMP_W'(MAX_WIDTH);
    end else begin
      width_eff = lw_ext;
    end
  end

  // position of the incoming pixel, a frame start restarts the image
  assign cur_col   = frame_start_i ? '0 : col_q;
  assign cur_phase = frame_start_i ? '0 : phase_q;
  assign cur_first = frame_start_i ? 1'b1 : first_q;
  assign col_inc   = CMP_W'(cur_col) + CMP_W'(1);
  assign phase_inc = cur_phase + MI_W'(1);

  // tags for the back end
  assign col_o            = cur_col;
  assign ctrl_o.rep       = (cur_phase == '0);
  assign ctrl_o.first_row = cur_first;
  assign pix_o            = pix_i;

  // next position
  always_comb begin
    col_d   = col_q;
    phase_d = phase_q;
    first_d = first_q;
    if (push) begin
      if (col_inc >= width_eff) begin
        col_d   = '0;
        phase_d = '0;
        first_d = 1'b0;
      end else begin
        col_d   = col_inc[COL_W-1:0];
        phase_d = (phase_inc >= mark_interval_i) ? '0 : phase_inc;
        first_d = cur_first;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      phase_q <= '0;
      first_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

  // a frame start puts the next pixel in column one or back in column zero
  a_frame_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && frame_start_i |=> col_q == COL_W'(1) || col_q == '0)
    else $error("column after frame start is wrong");

  // leaving the first row always happens at a row wrap
  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q && !first_d |-> push && col_d == '0)
    else $error("first row flag cleared outside a row wrap");

endmodule

/* rtl/mpcr_queue.sv */
// small fifo between the front and the back end
// depends on nothing but its parameters
module mpcr_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  input  logic             pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from an empty queue");

endmodule

/* rtl/mpcr_back.sv */
// back end: line store read, med prediction, line store write and output
// register; uses mpcr_pkg and mpcr_ram
module mpcr_back #(
  parameter int unsigned MAX_WIDTH = 512
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_col_i,
  input  mpcr_pkg::ctrl_t              q_ctrl_i,
  input  mpcr_pkg::pix_t               q_pix_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output mpcr_pkg::pix_t               pix_o,
  output logic                         replaced_o
);
  import mpcr_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  // stage holding the item whose line store data is being read
  logic             a_valid_q, a_valid_d;
  logic [COL_W-1:0] a_col_q;
  ctrl_t            a_ctrl_q;
  pix_t             a_pix_q;

  // neighbour history: last written pixel, its column, last upper pixel
  logic             last_valid_q;
  logic [COL_W-1:0] last_col_q;
  pix_t             last_res_q;
  pix_t             ul_q;

  // output register
  logic             out_valid_q, out_valid_d;
  pix_t             out_pix_q;
  logic             out_rep_q;

  pix_t             ram_rdata;
  pix_t             up;
  pix_t             left;
  pix_t             upper_left;
  pix_t             result;
  logic             fwd;
  logic             col_zero;
  logic             adv;
  logic             pop;

  // handshake between stage, queue and output register
  assign adv   = a_valid_q && (!out_valid_q || !out_stall_i);
  assign pop   = q_valid_i && (!a_valid_q || adv);
  assign pop_o = pop;

  // previous row store, read on pop, written when an item retires
  mpcr_ram #(
    .WIDTH($bits(pix_t)),
    .DEPTH(MAX_WIDTH)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (adv),
    .waddr_i(a_col_q),
    .wdata_i(result),
    .re_i   (pop),
    .raddr_i(q_col_i),
    .rdata_o(ram_rdata)
  );

  // neighbours, the item just ahead may have written our column
  assign fwd        = last_valid_q && (last_col_q == a_col_q);
  assign col_zero   = (a_col_q == '0);
  assign up         = a_ctrl_q.first_row ? '0 : (fwd ? last_res_q : ram_rdata);
  assign left       = col_zero ? '0 : last_res_q;
  assign upper_left = col_zero ? '0 : ul_q;
  assign result     = a_ctrl_q.rep ? med_pix(left, up, upper_left) : a_pix_q;

  // stage and output valid flags
  always_comb begin
    a_valid_d = a_valid_q;
    if (pop) begin
      a_valid_d = 1'b1;
    end else if (adv) begin
      a_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      last_valid_q <= 1'b0;
    end else begin
      a_valid_q   <= a_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        last_valid_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_col_q  <= q_col_i;
      a_ctrl_q <= q_ctrl_i;
      a_pix_q  <= q_pix_i;
    end
    if (adv) begin
      last_col_q <= a_col_q;
      last_res_q <= result;
      ul_q       <= up;
      out_pix_q  <= result;
      out_rep_q  <= a_ctrl_q.rep;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pix_o       = out_pix_q;
  assign replaced_o  = out_rep_q;

  // a retiring item always shows up at the output
  a_retire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("retired item missing at the output");

  // a replaced top left pixel has only zero neighbours
  a_corner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && a_ctrl_q.rep && a_ctrl_q.first_row && col_zero
    |=> out_pix_q == '0 && out_rep_q)
    else $error("top left prediction not zero");

  // the stage never drops an item: a held item stays while output stalls
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !adv |=> a_valid_q && $stable(a_col_q))
    else $error("stalled stage lost its item");

endmodule
